FILE: hw/rtl/esv_pkg.sv
package esv_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PRIME     = 2'd0,
        CFG_GENERATOR = 2'd1,
        CFG_PRIVATE   = 2'd2,
        CFG_PUBLIC    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic  start;
        t_word a;
        t_word d;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quo;
        t_word rem;
    } t_div_rsp;

    typedef struct packed {
        logic  start;
        t_word x;
        t_word y;
        t_word m;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_word prod;
    } t_mul_rsp;

    // (x + y) mod m, x and y already below m
    function automatic t_word add_mod(t_word x, t_word y, t_word m);
        logic [WORD_BITS:0] s;
        logic [WORD_BITS:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = s - {1'b0, m};
        return (s >= {1'b0, m}) ? d[WORD_BITS-1:0] : s[WORD_BITS-1:0];
    endfunction

    // (x - y) mod m, x and y already below m
    function automatic t_word sub_mod(t_word x, t_word y, t_word m);
        return (x >= y) ? (x - y) : (x + (m - y));
    endfunction

endpackage

FILE: hw/rtl/esv_div.sv
// restoring divider, one quotient bit per cycle
module esv_div
    import esv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic  r_busy, r_done;
    t_cnt  r_cnt;
    t_word r_rem, r_quo, r_d;

    logic [WORD_BITS:0] w_trial;
    logic [WORD_BITS:0] w_diff;
    logic               w_ge;

    assign w_trial = {r_rem, r_quo[WORD_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_ge    = (w_trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= t_cnt'(WORD_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.a;
            r_d   <= i_req.d;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[WORD_BITS-1:0] : w_trial[WORD_BITS-1:0];
            r_quo <= {r_quo[WORD_BITS-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

FILE: hw/rtl/esv_mul.sv
// modular multiplier, double-and-add over the multiplier bits, msb first
module esv_mul
    import esv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic  r_busy, r_done;
    t_cnt  r_cnt;
    t_word r_acc, r_x, r_y, r_m;

    t_word w_dbl, w_add;

    assign w_dbl = add_mod(r_acc, r_acc, r_m);
    assign w_add = r_y[WORD_BITS-1] ? add_mod(w_dbl, r_x, r_m) : w_dbl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= t_cnt'(WORD_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_x   <= i_req.x;
            r_y   <= i_req.y;
            r_m   <= i_req.m;
        end else if (r_busy) begin
            r_acc <= w_add;
            r_y   <= {r_y[WORD_BITS-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

FILE: hw/rtl/elgamal_sign_verify.sv
// elgamal signature engine, sign and verify over a configured prime p
//
// input beat (s_axis): tuser = mode (0 sign, 1 verify); tdata carries message,
// nonce, first and second signature parts to check, 32 bits each
// output beat (m_axis): tdata = first and second signature parts,
// tuser = signature valid and nonce rejected flags
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (prime, generator, private key, public key); write only while idle
//
// one item at a time: s_axis_tready is high only when the engine is idle.
// all work runs through one divider and one modular multiplier under a
// sequencer. a modular power takes 32 squarings plus one multiply per set
// exponent bit. signing costs the extended gcd (a divide and a multiply
// per euclid step) plus one power; a rejected nonce stops once the gcd is
// known. verifying costs three powers. a degenerate modulus (below two)
// goes straight to the result state.
//
// reset restores the default key set (p 467) and empties the engine.
// the result beat is held on m_axis until taken; a new item is taken
// only after the result has gone.
module elgamal_sign_verify
    import esv_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // message, nonce, check_first, check_second
    input  logic         s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // sign_first, sign_second
    output logic [1:0]   m_axis_tuser,  // signature_valid, nonce_rejected
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);

    typedef enum logic [23:0] {
        S_IDLE = 24'h000001,
        S_WAIT = 24'h000002,
        S_G1   = 24'h000004,
        S_G2   = 24'h000008,
        S_G3   = 24'h000010,
        S_G4   = 24'h000020,
        S_G5   = 24'h000040,
        S_G6   = 24'h000080,
        S_G7   = 24'h000100,
        S_G8   = 24'h000200,
        S_G9   = 24'h000400,
        S_G10  = 24'h000800,
        S_G11  = 24'h001000,
        S_PSQ  = 24'h002000,
        S_PMB  = 24'h004000,
        S_PML  = 24'h008000,
        S_V1   = 24'h010000,
        S_V2   = 24'h020000,
        S_V3   = 24'h040000,
        S_V4   = 24'h080000,
        S_V5   = 24'h100000,
        S_V6   = 24'h200000,
        S_V7   = 24'h400000,
        S_OUT  = 24'h800000
    } t_state;

    // configuration
    t_word r_cfg_p, r_cfg_g, r_cfg_a, r_cfg_b;
    t_word w_n;

    assign w_n = r_cfg_p - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_p <= t_word'(467);
            r_cfg_g <= t_word'(2);
            r_cfg_a <= t_word'(127);
            r_cfg_b <= t_word'(132);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PRIME:     r_cfg_p <= i_cfg_data;
                CFG_GENERATOR: r_cfg_g <= i_cfg_data;
                CFG_PRIVATE:   r_cfg_a <= i_cfg_data;
                CFG_PUBLIC:    r_cfg_b <= i_cfg_data;
                default:       r_cfg_p <= r_cfg_p;
            endcase
        end
    end

    // sequencer state
    t_state r_state, n_state, r_ret, n_ret, r_pret, n_pret;
    logic   r_mode, n_mode;
    t_word  r_msg, n_msg, r_nonce, n_nonce, r_c1, n_c1, r_c2, n_c2;
    t_word  r_r0, n_r0, r_r1, n_r1, r_t0, n_t0, r_t1, n_t1;
    t_word  r_quo, n_quo, r_rem, n_rem, r_prod, n_prod;
    t_word  r_base, n_base, r_exp, n_exp, r_acc, n_acc;
    t_cnt   r_bit, n_bit;
    t_word  r_first, n_first, r_aux, n_aux;
    t_word  r_o_first, n_o_first, r_o_second, n_o_second;
    logic   r_o_valid, n_o_valid, r_o_rej, n_o_rej;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    t_mul_req w_mul_req;
    t_mul_rsp w_mul_rsp;

    esv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    esv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    logic w_in_acc;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;  n_ret = r_ret;  n_pret = r_pret;
        n_mode = r_mode;    n_msg = r_msg;  n_nonce = r_nonce;
        n_c1 = r_c1;        n_c2 = r_c2;
        n_r0 = r_r0;  n_r1 = r_r1;  n_t0 = r_t0;  n_t1 = r_t1;
        n_quo = r_quo;  n_rem = r_rem;  n_prod = r_prod;
        n_base = r_base;  n_exp = r_exp;  n_acc = r_acc;  n_bit = r_bit;
        n_first = r_first;  n_aux = r_aux;
        n_o_first = r_o_first;  n_o_second = r_o_second;
        n_o_valid = r_o_valid;  n_o_rej = r_o_rej;
        w_div_req = '0;
        w_mul_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_mode  = s_axis_tuser;
                    n_msg   = s_axis_tdata[31:0];
                    n_nonce = s_axis_tdata[63:32];
                    n_c1    = s_axis_tdata[95:64];
                    n_c2    = s_axis_tdata[127:96];
                    n_o_first  = '0;
                    n_o_second = '0;
                    n_o_valid  = 1'b0;
                    n_o_rej    = 1'b0;
                    if (r_cfg_p < t_word'(2)) begin
                        // degenerate modulus: signing rejects, verifying fails
                        n_o_rej = !s_axis_tuser;
                        n_state = S_OUT;
                    end else if (!s_axis_tuser) begin
                        w_div_req = '{start: 1'b1, a: s_axis_tdata[63:32], d: w_n};
                        n_ret     = S_G1;
                        n_state   = S_WAIT;
                    end else begin
                        w_div_req = '{start: 1'b1, a: r_cfg_g, d: r_cfg_p};
                        n_ret     = S_V1;
                        n_state   = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (w_div_rsp.done) begin
                    n_quo   = w_div_rsp.quo;
                    n_rem   = w_div_rsp.rem;
                    n_state = r_ret;
                end
                if (w_mul_rsp.done) begin
                    n_prod  = w_mul_rsp.prod;
                    n_state = r_ret;
                end
            end
            // extended euclid for the nonce inverse mod p-1
            S_G1: begin
                n_r0 = w_n;
                n_r1 = r_rem;
                n_t0 = '0;
                n_t1 = (w_n == t_word'(1)) ? t_word'(0) : t_word'(1);
                n_state = S_G2;
            end
            S_G2: begin
                if (r_r1 == '0) begin
                    n_state = S_G5;
                end else begin
                    w_div_req = '{start: 1'b1, a: r_r0, d: r_r1};
                    n_ret     = S_G3;
                    n_state   = S_WAIT;
                end
            end
            S_G3: begin
                // quotient can equal the modulus only when it reduces to zero
                w_mul_req = '{start: 1'b1, x: (r_quo == w_n) ? t_word'(0) : r_quo,
                              y: r_t1, m: w_n};
                n_ret   = S_G4;
                n_state = S_WAIT;
            end
            S_G4: begin
                n_r0 = r_r1;
                n_r1 = r_rem;
                n_t0 = r_t1;
                n_t1 = sub_mod(r_t0, r_prod, w_n);
                n_state = S_G2;
            end
            S_G5: begin
                if (r_r0 != t_word'(1)) begin
                    n_o_rej = 1'b1;
                    n_state = S_OUT;
                end else begin
                    w_div_req = '{start: 1'b1, a: r_cfg_g, d: r_cfg_p};
                    n_ret     = S_G6;
                    n_state   = S_WAIT;
                end
            end
            S_G6: begin
                n_base = r_rem;
                n_exp  = r_nonce;
                n_acc  = t_word'(1);
                n_bit  = t_cnt'(WORD_BITS - 1);
                n_pret = S_G7;
                n_state = S_PSQ;
            end
            S_G7: begin
                n_first   = r_acc;
                w_div_req = '{start: 1'b1, a: r_msg, d: w_n};
                n_ret     = S_G8;
                n_state   = S_WAIT;
            end
            S_G8: begin
                n_aux     = r_rem;
                w_div_req = '{start: 1'b1, a: r_cfg_a, d: w_n};
                n_ret     = S_G9;
                n_state   = S_WAIT;
            end
            S_G9: begin
                w_mul_req = '{start: 1'b1, x: r_rem,
                              y: (r_first == w_n) ? t_word'(0) : r_first, m: w_n};
                n_ret   = S_G10;
                n_state = S_WAIT;
            end
            S_G10: begin
                w_mul_req = '{start: 1'b1, x: r_t0,
                              y: sub_mod(r_aux, r_prod, w_n), m: w_n};
                n_ret   = S_G11;
                n_state = S_WAIT;
            end
            S_G11: begin
                n_o_first  = r_first;
                n_o_second = r_prod;
                n_state    = S_OUT;
            end
            // modular power, square and multiply from the top exponent bit
            S_PSQ: begin
                w_mul_req = '{start: 1'b1, x: r_acc, y: r_acc, m: r_cfg_p};
                n_ret   = S_PMB;
                n_state = S_WAIT;
            end
            S_PMB: begin
                n_acc = r_prod;
                if (r_exp[r_bit]) begin
                    w_mul_req = '{start: 1'b1, x: r_prod, y: r_base, m: r_cfg_p};
                    n_ret   = S_PML;
                    n_state = S_WAIT;
                end else if (r_bit == '0) begin
                    n_state = r_pret;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_state = S_PSQ;
                end
            end
            S_PML: begin
                n_acc = r_prod;
                if (r_bit == '0) begin
                    n_state = r_pret;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_state = S_PSQ;
                end
            end
            // verify: g^m against b^c1 * c1^c2
            S_V1: begin
                n_base = r_rem;
                n_exp  = r_msg;
                n_acc  = t_word'(1);
                n_bit  = t_cnt'(WORD_BITS - 1);
                n_pret = S_V2;
                n_state = S_PSQ;
            end
            S_V2: begin
                n_first   = r_acc;
                w_div_req = '{start: 1'b1, a: r_cfg_b, d: r_cfg_p};
                n_ret     = S_V3;
                n_state   = S_WAIT;
            end
            S_V3: begin
                n_base = r_rem;
                n_exp  = r_c1;
                n_acc  = t_word'(1);
                n_bit  = t_cnt'(WORD_BITS - 1);
                n_pret = S_V4;
                n_state = S_PSQ;
            end
            S_V4: begin
                n_aux     = r_acc;
                w_div_req = '{start: 1'b1, a: r_c1, d: r_cfg_p};
                n_ret     = S_V5;
                n_state   = S_WAIT;
            end
            S_V5: begin
                n_base = r_rem;
                n_exp  = r_c2;
                n_acc  = t_word'(1);
                n_bit  = t_cnt'(WORD_BITS - 1);
                n_pret = S_V6;
                n_state = S_PSQ;
            end
            S_V6: begin
                w_mul_req = '{start: 1'b1, x: r_aux, y: r_acc, m: r_cfg_p};
                n_ret   = S_V7;
                n_state = S_WAIT;
            end
            S_V7: begin
                n_o_valid = (r_prod == r_first);
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_pret  <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_pret  <= n_pret;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;  r_msg <= n_msg;  r_nonce <= n_nonce;
        r_c1 <= n_c1;      r_c2 <= n_c2;
        r_r0 <= n_r0;  r_r1 <= n_r1;  r_t0 <= n_t0;  r_t1 <= n_t1;
        r_quo <= n_quo;  r_rem <= n_rem;  r_prod <= n_prod;
        r_base <= n_base;  r_exp <= n_exp;  r_acc <= n_acc;  r_bit <= n_bit;
        r_first <= n_first;  r_aux <= n_aux;
        r_o_first <= n_o_first;  r_o_second <= n_o_second;
        r_o_valid <= n_o_valid;  r_o_rej <= n_o_rej;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {r_o_second, r_o_first};
    assign m_axis_tuser  = {r_o_rej, r_o_valid};

    // the two units are never launched in the same cycle
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_div_req.start && w_mul_req.start))
        else $error("divider and multiplier started together");

    // a rejected nonce carries zero signature parts
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0))
        else $error("rejected nonce with non-zero parts");

    // a sign result never claims a valid signature
    a_valid_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (r_mode && !m_axis_tuser[1]))
        else $error("valid flag outside verify mode");

    // an accepted beat starts work straight away
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("accepted beat left the engine idle");

endmodule
